>>> design/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared types and constants for the two-server assignment core.
// ----------------------------------------------------------------------------
package tsa_pkg;

	localparam int COORD_W = 16;
	localparam int POS_W   = 2 * COORD_W;
	localparam int DIST_W  = 23;
	localparam int HOP_W   = COORD_W + 1;

	localparam logic [COORD_W-1:0] START_ONE = 16'd1;
	localparam logic [COORD_W-1:0] GRID_RST  = 16'd1000;

	localparam logic KIND_TOTAL  = 1'b0;
	localparam logic KIND_ASSIGN = 1'b1;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ZERO,
		ST_OP0,
		ST_OP1,
		ST_OP2,
		ST_OP3,
		ST_CALC,
		ST_FIN,
		ST_TOTAL_RD,
		ST_TOTAL_EMIT
	} st_t;

	// event store read address select
	typedef enum logic [1:0] {
		EV_NX,
		EV_L,
		EV_R
	} ev_sel_t;

	// cost table read address select
	typedef enum logic [1:0] {
		C_CUR,
		C_A,
		C_B
	} c_sel_t;

	typedef struct packed {
		logic    ev_wr;
		logic    trace;
		ev_sel_t ev_sel;
		c_sel_t  c_sel;
		logic    cap_a;
		logic    cap_b;
		logic    cap_d;
		logic    cap_ab;
		logic    tbl_wr;
		logic    tbl_zero;
		logic    fill_adv;
		logic    trace_init;
		logic    trace_adv;
		logic    out_total;
		logic    out_assign;
	} cmd_t;

	typedef struct packed {
		logic cell_end;
		logic fill_last;
		logic trace_final;
		logic out_free;
	} sts_t;

endpackage

>>> design/tsa_ctrl.sv
// ----------------------------------------------------------------------------
// tsa_ctrl
// Sequencer: loads events, zero-fills and sweeps the cost table, emits the total, then traces back.
// ----------------------------------------------------------------------------
module tsa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          last,
	input  tsa_pkg::sts_t sts,
	output logic          in_stall,
	output tsa_pkg::cmd_t cmd
);

	tsa_pkg::st_t state_q, state_n;
	logic         trace_q, trace_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsa_pkg::ST_IDLE;
			trace_q <= 1'b0;
		end else begin
			state_q <= state_n;
			trace_q <= trace_n;
		end
	end

	// next state and commands
	always_comb begin
		state_n   = state_q;
		trace_n   = trace_q;
		in_stall  = 1'b1;
		cmd       = '0;
		cmd.trace = trace_q;
		cmd.ev_sel = tsa_pkg::EV_NX;
		cmd.c_sel  = tsa_pkg::C_CUR;
		unique case (state_q)
			tsa_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				trace_n  = 1'b0;
				if (in_valid) begin
					cmd.ev_wr = 1'b1;
					if (last) state_n = tsa_pkg::ST_ZERO;
				end
			end
			tsa_pkg::ST_ZERO: begin
				cmd.tbl_wr   = 1'b1;
				cmd.tbl_zero = 1'b1;
				cmd.fill_adv = 1'b1;
				if (sts.fill_last) begin
					cmd.trace_init = 1'b1;
					trace_n = 1'b1;
					state_n = tsa_pkg::ST_TOTAL_RD;
				end else if (sts.cell_end) begin
					state_n = tsa_pkg::ST_OP0;
				end
			end
			tsa_pkg::ST_OP0: begin
				cmd.ev_sel = tsa_pkg::EV_NX;
				cmd.c_sel  = tsa_pkg::C_A;
				state_n    = tsa_pkg::ST_OP1;
			end
			tsa_pkg::ST_OP1: begin
				cmd.cap_a  = 1'b1;
				cmd.ev_sel = tsa_pkg::EV_L;
				cmd.c_sel  = tsa_pkg::C_B;
				state_n    = tsa_pkg::ST_OP2;
			end
			tsa_pkg::ST_OP2: begin
				cmd.cap_b  = 1'b1;
				cmd.ev_sel = tsa_pkg::EV_R;
				state_n    = tsa_pkg::ST_OP3;
			end
			tsa_pkg::ST_OP3: begin
				cmd.cap_d = 1'b1;
				state_n   = tsa_pkg::ST_CALC;
			end
			tsa_pkg::ST_CALC: begin
				cmd.cap_ab = 1'b1;
				state_n    = tsa_pkg::ST_FIN;
			end
			tsa_pkg::ST_FIN: begin
				if (!trace_q) begin
					cmd.tbl_wr   = 1'b1;
					cmd.fill_adv = 1'b1;
					if (sts.fill_last) begin
						cmd.trace_init = 1'b1;
						trace_n = 1'b1;
						state_n = tsa_pkg::ST_TOTAL_RD;
					end else begin
						state_n = tsa_pkg::ST_OP0;
					end
				end else if (sts.out_free) begin
					cmd.out_assign = 1'b1;
					cmd.trace_adv  = 1'b1;
					state_n = sts.trace_final ? tsa_pkg::ST_IDLE : tsa_pkg::ST_OP0;
				end
			end
			tsa_pkg::ST_TOTAL_RD: begin
				state_n = tsa_pkg::ST_TOTAL_EMIT;
			end
			tsa_pkg::ST_TOTAL_EMIT: begin
				if (sts.out_free) begin
					cmd.out_total = 1'b1;
					state_n = tsa_pkg::ST_OP0;
				end
			end
			default: state_n = tsa_pkg::ST_IDLE;
		endcase
	end

endmodule

>>> design/tsa_dpath.sv
// ----------------------------------------------------------------------------
// tsa_dpath
// Event store, cost table, distance arithmetic and the output register.
// ----------------------------------------------------------------------------
module tsa_dpath #(
	parameter int MAX_EVENTS = 63
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tsa_pkg::cmd_t                cmd,
	output tsa_pkg::sts_t                sts,
	input  logic                         cfg_we,
	input  logic [tsa_pkg::COORD_W-1:0]  cfg_wdata,
	input  logic [tsa_pkg::COORD_W-1:0]  event_row,
	input  logic [tsa_pkg::COORD_W-1:0]  event_col,
	input  logic                         last,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic                         record_kind,
	output logic [tsa_pkg::DIST_W-1:0]   total_distance,
	output logic                         server_choice,
	output logic                         final_record
);

	localparam int IW       = $clog2(MAX_EVENTS + 1);
	localparam int EV_DEPTH = 1 << IW;
	localparam int C_DEPTH  = 1 << (2 * IW);
	localparam int PW       = tsa_pkg::POS_W;
	localparam int CW       = tsa_pkg::COORD_W;
	localparam int DW       = tsa_pkg::DIST_W;
	localparam int HW       = tsa_pkg::HOP_W;

	localparam logic [CW-1:0] START_ONE_W = tsa_pkg::START_ONE;

	logic [PW-1:0] ev_mem [0:EV_DEPTH-1];
	logic [DW-1:0] cost_mem [0:C_DEPTH-1];

	logic [CW-1:0]   grid_q;
	logic [IW-1:0]   cnt_q, w_q, m_q, k_q, tl_q, tr_q;
	logic            half_q;
	logic [PW-1:0]   ev_rdata_q, nx_q, p1_q;
	logic [DW-1:0]   cost_rdata_q, ca_q, cb_q, a_q, b_q;
	logic [HW-1:0]   d1_q, d2_q;
	logic            out_valid_q;

	logic [IW-1:0]   l, r, mx, mp1, cnt_inc, w_new;
	logic [IW-1:0]   ev_addr;
	logic [2*IW-1:0] c_addr, c_waddr;
	logic            full;
	logic [PW-1:0]   p2, grid_pos;
	logic            pick_one;
	logic [DW-1:0]   best;

	function automatic logic [HW-1:0] hop(input logic [PW-1:0] pa, input logic [PW-1:0] pb);
		logic [CW-1:0] dr, dc;
		dr = (pa[PW-1:CW] > pb[PW-1:CW]) ? pa[PW-1:CW] - pb[PW-1:CW]
		                                 : pb[PW-1:CW] - pa[PW-1:CW];
		dc = (pa[CW-1:0] > pb[CW-1:0]) ? pa[CW-1:0] - pb[CW-1:0]
		                               : pb[CW-1:0] - pa[CW-1:0];
		return {1'b0, dr} + {1'b0, dc};
	endfunction

	// current cell indices
	assign l   = cmd.trace ? tl_q : (half_q ? k_q : m_q);
	assign r   = cmd.trace ? tr_q : (half_q ? m_q : k_q);
	assign mx  = (l > r) ? l : r;
	assign mp1 = mx + IW'(1);

	assign full     = (cnt_q >= IW'(MAX_EVENTS));
	assign cnt_inc  = cnt_q + IW'(1);
	assign w_new    = full ? cnt_q : cnt_inc;
	assign grid_pos = {grid_q, grid_q};

	// read address selection
	always_comb begin
		case (cmd.ev_sel)
			tsa_pkg::EV_L: ev_addr = l;
			tsa_pkg::EV_R: ev_addr = r;
			default:       ev_addr = mp1;
		endcase
		case (cmd.c_sel)
			tsa_pkg::C_A: c_addr = {mp1, r};
			tsa_pkg::C_B: c_addr = {l, mp1};
			default:      c_addr = {l, r};
		endcase
	end

	assign c_waddr  = {l, r};
	assign p2       = (r == '0) ? grid_pos : ev_rdata_q;
	assign pick_one = (a_q < b_q);
	assign best     = pick_one ? a_q : b_q;

	// event store
	always_ff @(posedge clk) begin
		if (cmd.ev_wr && !full) ev_mem[cnt_inc] <= {event_row, event_col};
		ev_rdata_q <= ev_mem[ev_addr];
	end

	// cost table
	always_ff @(posedge clk) begin
		if (cmd.tbl_wr) cost_mem[c_waddr] <= cmd.tbl_zero ? '0 : best;
		cost_rdata_q <= cost_mem[c_addr];
	end

	// operand and sum registers
	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			nx_q <= ev_rdata_q;
			ca_q <= cost_rdata_q;
		end
		if (cmd.cap_b) begin
			p1_q <= (l == '0) ? {START_ONE_W, START_ONE_W} : ev_rdata_q;
			cb_q <= cost_rdata_q;
		end
		if (cmd.cap_d) begin
			d1_q <= hop(nx_q, p1_q);
			d2_q <= hop(p2, nx_q);
		end
		if (cmd.cap_ab) begin
			a_q <= DW'(d1_q) + ca_q;
			b_q <= DW'(d2_q) + cb_q;
		end
	end

	// counters and loop indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= tsa_pkg::GRID_RST;
			cnt_q  <= '0;
			w_q    <= '0;
			m_q    <= '0;
			k_q    <= '0;
			half_q <= 1'b0;
			tl_q   <= '0;
			tr_q   <= '0;
		end else begin
			if (cfg_we) grid_q <= cfg_wdata;
			if (cmd.ev_wr) begin
				if (last) begin
					cnt_q  <= '0;
					w_q    <= w_new;
					m_q    <= w_new;
					k_q    <= '0;
					half_q <= 1'b0;
				end else if (!full) begin
					cnt_q <= cnt_inc;
				end
			end
			if (cmd.fill_adv) begin
				if (!half_q) begin
					half_q <= 1'b1;
				end else begin
					half_q <= 1'b0;
					if (k_q == m_q) begin
						m_q <= m_q - IW'(1);
						k_q <= '0;
					end else begin
						k_q <= k_q + IW'(1);
					end
				end
			end
			if (cmd.trace_init) begin
				tl_q <= '0;
				tr_q <= '0;
			end else if (cmd.trace_adv) begin
				if (pick_one) tl_q <= mp1;
				else          tr_q <= mp1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_total || cmd.out_assign) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_total) begin
			record_kind    <= tsa_pkg::KIND_TOTAL;
			total_distance <= cost_rdata_q;
			server_choice  <= 1'b0;
			final_record   <= (w_q == '0);
		end else if (cmd.out_assign) begin
			record_kind    <= tsa_pkg::KIND_ASSIGN;
			total_distance <= '0;
			server_choice  <= !pick_one;
			final_record   <= (mp1 == w_q);
		end
	end

	assign out_valid = out_valid_q;

	// status
	assign sts.cell_end    = half_q && (k_q == m_q);
	assign sts.fill_last   = half_q && (k_q == m_q) && (m_q == '0);
	assign sts.trace_final = (mp1 == w_q);
	assign sts.out_free    = !out_valid_q || !out_stall;

endmodule

>>> design/two_server_assignment_dp_core.sv
// Loading: one event per cycle; no result until the event that carries last.
// Run for W events: the cost table cells with an index of W are zero-filled,
// then each remaining cell is computed in turn, the total is emitted and the
// events are traced back, one record each; the event store and cost table each
// have a single read port. Inputs are stalled during a run.
// Reset is asynchronous, active low; memories are not cleared.
// ----------------------------------------------------------------------------
// two_server_assignment_dp_core
// Offline two-server assignment on a grid, controller plus datapath.
// ----------------------------------------------------------------------------
module two_server_assignment_dp_core #(
	parameter int MAX_EVENTS = 63
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [tsa_pkg::COORD_W-1:0]  cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [tsa_pkg::COORD_W-1:0]  event_row,
	input  logic [tsa_pkg::COORD_W-1:0]  event_col,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         record_kind,
	output logic [tsa_pkg::DIST_W-1:0]   total_distance,
	output logic                         server_choice,
	output logic                         final_record
);

	tsa_pkg::cmd_t cmd;
	tsa_pkg::sts_t sts;

	tsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	tsa_dpath #(
		.MAX_EVENTS (MAX_EVENTS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.event_row      (event_row),
		.event_col      (event_col),
		.last           (last),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.record_kind    (record_kind),
		.total_distance (total_distance),
		.server_choice  (server_choice),
		.final_record   (final_record)
	);

endmodule

>>> design/tsa_checker.sv
// ----------------------------------------------------------------------------
// tsa_checker
// Port-level checks for the two-server assignment core.
// ----------------------------------------------------------------------------
module tsa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         last,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         record_kind,
	input logic [tsa_pkg::DIST_W-1:0]   total_distance,
	input logic                         server_choice,
	input logic                         final_record
);

	// a held result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// a held result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(total_distance) && $stable(record_kind)
			&& $stable(server_choice) && $stable(final_record))
		else $error("output item changed while stalled");

	// closing event starts a run that blocks input
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last |=> in_stall)
		else $error("input taken after the closing event");

	// the total record never ends a run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == tsa_pkg::KIND_TOTAL |-> !final_record && !server_choice)
		else $error("bad total record");

endmodule

bind two_server_assignment_dp_core tsa_checker u_tsa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.last           (last),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.record_kind    (record_kind),
	.total_distance (total_distance),
	.server_choice  (server_choice),
	.final_record   (final_record)
);
